/* rtl/sha1_pkg.sv */
// ---------------------------------------------------------------------------
// sha1_pkg
// Shared constants and helpers for the SHA-1 hash engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1_pkg;

	localparam int unsigned CHAIN_WORDS = 5;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 80;

	typedef logic [31:0] word_t;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	localparam word_t INIT_H0 = 32'h67452301;
	localparam word_t INIT_H1 = 32'hefcdab89;
	localparam word_t INIT_H2 = 32'h98badcfe;
	localparam word_t INIT_H3 = 32'h10325476;
	localparam word_t INIT_H4 = 32'hc3d2e1f0;

	localparam word_t K_R0 = 32'h5a827999;
	localparam word_t K_R1 = 32'h6ed9eba1;
	localparam word_t K_R2 = 32'h8f1bbcdc;
	localparam word_t K_R3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic word_t init_chain(input logic [2:0] idx);
		word_t v;
		begin
			unique case (idx)
				3'd0: v = INIT_H0;
				3'd1: v = INIT_H1;
				3'd2: v = INIT_H2;
				3'd3: v = INIT_H3;
				default: v = INIT_H4;
			endcase
			return v;
		end
	endfunction

endpackage

/* rtl/sha1_hash_engine_top.sv */
// ---------------------------------------------------------------------------
// sha1_hash_engine_top
// SHA-1 digest engine: byte-wide message input, five-word digest output.
// ---------------------------------------------------------------------------
// Request channel msg_*: action (absorb / finish) and data_byte, accepted
// when msg_valid is high and msg_stall is low.
// Result channel dig_*: digest_word, word_index, last_word, taken when
// dig_valid is high and dig_stall is low.
// The 64th byte of a block starts the compression: a read-setup step, 80
// rounds (one round per cycle) and a fold step; msg_stall is high until
// the fold is done.
// The 16-word block buffer is a synchronous RAM with byte enables (one
// write and one read port); the round loop reads it for rounds 0..15 and
// then runs on a 16-word schedule window.
// Finish pads in place: it writes the pad byte, zeroes later words up to
// the length words, writes the two length words, then compresses; when
// the length does not fit, one more block (zero sweep plus compression)
// comes first.
// The five digest words then appear one per cycle while dig_stall is low;
// a stalled word holds. msg_stall stays high from finish to the last word.
// Reset loads the initial chain value and clears the bit count; the RAM
// content is not cleared and never needs to be.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_hash_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ZERO,
		S_LEN,
		S_PREP,
		S_ROUND,
		S_FOLD,
		S_OUT
	} state_t;

	state_t state_q;

	sha1_pkg::word_t chain_q [sha1_pkg::CHAIN_WORDS];
	logic [63:0]     bits_q;
	logic [6:0]      rnd_q;
	logic [4:0]      ptr_q;
	logic            fin_q;
	logic            two_blk_q;
	logic [2:0]      idx_q;

	sha1_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	sha1_pkg::word_t w_q [sha1_pkg::BLOCK_WORDS];
	sha1_pkg::word_t rd_q;

	sha1_pkg::word_t mem [sha1_pkg::BLOCK_WORDS];

	logic            mem_we;
	logic [3:0]      mem_waddr;
	logic [3:0]      mem_be;
	sha1_pkg::word_t mem_wdata;
	logic [3:0]      mem_raddr;

	logic       msg_fire;
	logic       dig_fire;
	logic [5:0] pos;
	logic [1:0] lane;
	logic [4:0] zero_limit;

	sha1_pkg::word_t w_cur, w_mix, f_val, k_val, t_val;

	assign msg_fire   = msg_valid && !msg_stall;
	assign dig_fire   = dig_valid && !dig_stall;
	assign pos        = bits_q[8:3];
	assign lane       = pos[1:0];
	assign zero_limit = two_blk_q ? 5'd16 : 5'd14;

	assign msg_stall   = (state_q != S_IDLE);
	assign dig_valid   = (state_q == S_OUT);
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd4);

	// buffer write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos[5:2];
		mem_be    = 4'hf;
		mem_wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_we = msg_fire;
				if (action == sha1_pkg::ACT_ABSORB) begin
					mem_be    = (lane == 2'd0) ? 4'hf : (4'b1000 >> lane);
					mem_wdata = {data_byte, 24'h0} >> {lane, 3'b000};
				end else begin
					mem_be    = 4'hf >> lane;
					mem_wdata = {sha1_pkg::PAD_BYTE, 24'h0} >> {lane, 3'b000};
				end
			end
			S_ZERO: begin
				mem_we    = (ptr_q < zero_limit);
				mem_waddr = ptr_q[3:0];
			end
			S_LEN: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[3:0];
				mem_wdata = ptr_q[0] ? bits_q[31:0] : bits_q[63:32];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_raddr = (state_q == S_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int l = 0; l < 4; l++) begin
				if (mem_be[l]) begin
					mem[mem_waddr][8*l +: 8] <= mem_wdata[8*l +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[mem_raddr];
	end

	// round function
	always_comb begin
		w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_cur = (rnd_q < 7'd16) ? rd_q : {w_mix[30:0], w_mix[31]};
		if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1_pkg::K_R0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K_R1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1_pkg::K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K_R3;
		end
		t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_cur + k_val;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == S_ROUND) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int j = 0; j < sha1_pkg::BLOCK_WORDS - 1; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[sha1_pkg::BLOCK_WORDS-1] <= w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bits_q    <= '0;
			rnd_q     <= '0;
			ptr_q     <= '0;
			fin_q     <= 1'b0;
			two_blk_q <= 1'b0;
			idx_q     <= '0;
			for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++) begin
				chain_q[i] <= sha1_pkg::init_chain(3'(i));
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (msg_fire) begin
						if (action == sha1_pkg::ACT_ABSORB) begin
							bits_q <= bits_q + 64'd8;
							fin_q  <= 1'b0;
							if (pos == 6'd63) begin
								state_q <= S_PREP;
							end
						end else begin
							fin_q     <= 1'b1;
							two_blk_q <= (pos[5:3] == 3'b111);
							ptr_q     <= {1'b0, pos[5:2]} + 5'd1;
							state_q   <= S_ZERO;
						end
					end
				end
				S_ZERO: begin
					if (ptr_q < zero_limit) begin
						ptr_q <= ptr_q + 5'd1;
					end else if (two_blk_q) begin
						state_q <= S_PREP;
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					ptr_q <= ptr_q + 5'd1;
					if (ptr_q[0]) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(sha1_pkg::ROUNDS - 1)) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (two_blk_q) begin
						two_blk_q <= 1'b0;
						ptr_q     <= '0;
						state_q   <= S_ZERO;
					end else begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (dig_fire) begin
						if (idx_q == 3'd4) begin
							idx_q   <= '0;
							bits_q  <= '0;
							fin_q   <= 1'b0;
							state_q <= S_IDLE;
							for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++) begin
								chain_q[i] <= sha1_pkg::init_chain(3'(i));
							end
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("request accepted while digest pending");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (rnd_q < 7'd80))
		else $error("round counter out of range");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (word_index <= 3'd4))
		else $error("digest word index out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_fire && last_word) |=> (!dig_valid && bits_q == 64'd0))
		else $error("digest sequence did not end after last word");

endmodule
